@@ rtl/dhkv_pkg.sv @@
// Shared types and constants of the double-hashing key/value table.
// No dependencies; the top level and the testbench use it by scoped names.
`timescale 1ns / 1ps

package dhkv_pkg;

    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 9;
    localparam int SIZE_W  = 9;
    localparam int PRIME_W = 8;
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 1;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_mark;

    localparam t_cmd CMD_GET    = 2'd0;
    localparam t_cmd CMD_PUT    = 2'd1;
    localparam t_cmd CMD_REMOVE = 2'd2;
    localparam t_cmd CMD_NONE   = 2'd3;

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_ABSENT  = 2'd1;
    localparam t_status ST_PRESENT = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

    localparam t_mark MARK_EMPTY = 2'd0;
    localparam t_mark MARK_LIVE  = 2'd1;
    localparam t_mark MARK_DEAD  = 2'd2;

    localparam logic [IDX_W-1:0] CFG_TABLE_SIZE = 1'd0;
    localparam logic [IDX_W-1:0] CFG_STEP_PRIME = 1'd1;

endpackage

@@ rtl/dhkv_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dhkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dhkv_mod.sv @@
// Shared bit-serial remainder unit: one compare and subtract per cycle.
// Depends on nothing; used by the table sequencer for all three reductions.
`timescale 1ns / 1ps

module dhkv_mod #(
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [8:0]    i_divisor,
    output logic          o_done,
    output logic [8:0]    o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [8:0]    r_div;
    logic [8:0]    r_rem;
    logic [9:0]    w_trial;
    logic [8:0]    n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[DW-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = 9'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = 9'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= CW'(r_cnt + 1'b1);
            if (r_cnt == CW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/double_hash_key_value_table.sv @@
// Top level of the double-hashing key/value table: sequencer, stores, ports.
// Depends on dhkv_pkg, dhkv_ram and dhkv_mod.
//
// Channel   Dir  Handshake               Contents (lowest bit first)
// s_axis    in   i_s_tvalid/o_s_tready   cmd[1:0], key[65:2], value[97:66]
// m_axis    out  o_m_tvalid/i_m_tready   status[1:0], value_out[33:2], count[42:34]
// cfg       in   i_cfg_we                index 0 table_size, 1 step_prime
//
// A GET, PUT or REMOVE request runs three remainder passes, then a read and a check
// per probed slot, then loads the result register; a NONE request only loads it.
// The remainder passes run on one shared compare-and-subtract unit.
// After reset the slot marks are cleared one per cycle, covering all TABLE_DEPTH slots.
// A waiting result stalls only the final load, not the search.
`timescale 1ns / 1ps

module double_hash_key_value_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [103:0]                      i_s_tdata,  // cmd, key, value
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [47:0]                       o_m_tdata,  // status, value_out, count
    input  logic                              i_cfg_we,
    input  logic [dhkv_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [dhkv_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int KW    = 8 * KEY_BYTES;
    localparam int SUM_W = $clog2(KEY_BYTES * 255 + 1);
    localparam int CAP   = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MODN   = 3'd2;
    localparam logic [2:0] S_MODP   = 3'd3;
    localparam logic [2:0] S_MODS   = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_CHECK  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]                       r_state;
    logic [AW:0]                      r_clr;
    logic [dhkv_pkg::SIZE_W-1:0]      r_size;
    logic [dhkv_pkg::PRIME_W-1:0]     r_prime;
    logic [dhkv_pkg::CNT_W-1:0]       r_count;
    dhkv_pkg::t_cmd                   r_cmd;
    logic [KW-1:0]                    r_key;
    logic [VALUE_WIDTH-1:0]           r_val;
    logic [SUM_W-1:0]                 r_sum;
    logic [8:0]                       r_slot;
    logic [8:0]                       r_step;
    logic [8:0]                       r_cnt;
    dhkv_pkg::t_status                r_status;
    logic [dhkv_pkg::VAL_W-1:0]       r_vout;
    logic                             r_out_valid;
    dhkv_pkg::t_status                r_out_status;
    logic [dhkv_pkg::VAL_W-1:0]       r_out_vout;
    logic [dhkv_pkg::CNT_W-1:0]       r_out_count;

    dhkv_pkg::t_cmd                   w_in_cmd;
    logic [dhkv_pkg::KEY_W-1:0]       w_in_key;
    logic [KW-1:0]                    w_norm;
    logic [SUM_W-1:0]                 w_sum;
    logic                             w_alive;
    logic [8:0]                       w_n;
    logic [7:0]                       w_p;
    logic                             w_s_acc;
    logic                             w_mod_start;
    logic [SUM_W-1:0]                 w_mod_dvd;
    logic [8:0]                       w_mod_div;
    logic                             w_mod_done;
    logic [8:0]                       w_mod_rem;
    logic [8:0]                       w_step_raw;
    logic [9:0]                       w_slot_sum;
    logic [8:0]                       w_slot_next;
    logic                             w_last;
    logic                             w_match;
    logic                             w_load;

    dhkv_pkg::t_mark                  w_mark_rd;
    logic [KW-1:0]                    w_key_rd;
    logic [VALUE_WIDTH-1:0]           w_val_rd;
    logic                             w_mark_we;
    logic [AW-1:0]                    w_mark_waddr;
    dhkv_pkg::t_mark                  w_mark_wdata;
    logic                             w_kv_we;
    logic [AW-1:0]                    w_addr;

    assign w_in_cmd = i_s_tdata[1:0];
    assign w_in_key = i_s_tdata[65:2];
    assign w_s_acc  = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        w_norm  = '0;
        w_sum   = '0;
        w_alive = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            w_alive = w_alive && (w_in_key[8*i +: 8] != 8'd0);
            if (w_alive) begin
                w_norm[8*i +: 8] = w_in_key[8*i +: 8];
                w_sum = SUM_W'(w_sum + w_in_key[8*i +: 8]);
            end
        end
    end

    always_comb begin
        if (r_size == '0) begin
            w_n = 9'd1;
        end else if (r_size > 9'(CAP)) begin
            w_n = 9'(CAP);
        end else begin
            w_n = r_size;
        end
        w_p = (r_prime == '0) ? 8'd1 : r_prime;
    end

    assign w_step_raw = {1'b0, w_p} - w_mod_rem;

    always_comb begin
        w_mod_start = 1'b0;
        w_mod_dvd   = w_sum;
        w_mod_div   = w_n;
        unique case (r_state)
            S_IDLE: begin
                w_mod_start = w_s_acc && (w_in_cmd != dhkv_pkg::CMD_NONE);
            end
            S_MODN: begin
                w_mod_start = w_mod_done;
                w_mod_dvd   = r_sum;
                w_mod_div   = {1'b0, w_p};
            end
            S_MODP: begin
                w_mod_start = w_mod_done;
                w_mod_dvd   = SUM_W'(w_step_raw);
            end
            default: begin
                w_mod_start = 1'b0;
            end
        endcase
    end

    dhkv_mod #(.DW(SUM_W)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_mod_div),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign w_addr      = AW'(r_slot);
    assign w_slot_sum  = {1'b0, r_slot} + {1'b0, r_step};
    assign w_slot_next = (w_slot_sum >= {1'b0, w_n}) ? 9'(w_slot_sum - {1'b0, w_n})
                                                     : 9'(w_slot_sum);
    assign w_last      = (r_cnt == 9'(w_n - 9'd1));
    assign w_match     = (w_key_rd == r_key);

    always_comb begin
        w_mark_we    = 1'b0;
        w_mark_waddr = w_addr;
        w_mark_wdata = dhkv_pkg::MARK_LIVE;
        w_kv_we      = 1'b0;
        if (r_state == S_CLEAR) begin
            w_mark_we    = 1'b1;
            w_mark_waddr = r_clr[AW-1:0];
            w_mark_wdata = dhkv_pkg::MARK_EMPTY;
        end else if (r_state == S_CHECK) begin
            if (r_cmd == dhkv_pkg::CMD_PUT) begin
                w_mark_we = (w_mark_rd != dhkv_pkg::MARK_LIVE);
                w_kv_we   = w_mark_we;
            end else if (r_cmd == dhkv_pkg::CMD_REMOVE) begin
                w_mark_we    = (w_mark_rd == dhkv_pkg::MARK_LIVE) && w_match;
                w_mark_wdata = dhkv_pkg::MARK_DEAD;
            end
        end
    end

    dhkv_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (w_mark_we),
        .i_waddr (w_mark_waddr),
        .i_wdata (w_mark_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_mark_rd)
    );

    dhkv_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_kv_we),
        .i_waddr (w_addr),
        .i_wdata (r_key),
        .i_raddr (w_addr),
        .o_rdata (w_key_rd)
    );

    dhkv_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_kv_we),
        .i_waddr (w_addr),
        .i_wdata (r_val),
        .i_raddr (w_addr),
        .o_rdata (w_val_rd)
    );

    assign w_load = (r_state == S_FINISH) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= 9'd256;
            r_prime <= 8'd251;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dhkv_pkg::CFG_TABLE_SIZE: r_size  <= i_cfg_data;
                dhkv_pkg::CFG_STEP_PRIME: r_prime <= i_cfg_data[7:0];
                default: r_size <= r_size;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= (AW + 1)'(r_clr + 1'b1);
                    if (r_clr == (AW + 1)'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_state <= (w_in_cmd == dhkv_pkg::CMD_NONE) ? S_FINISH : S_MODN;
                    end
                end
                S_MODN: begin
                    if (w_mod_done) begin
                        r_state <= S_MODP;
                    end
                end
                S_MODP: begin
                    if (w_mod_done) begin
                        r_state <= S_MODS;
                    end
                end
                S_MODS: begin
                    if (w_mod_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_cmd == dhkv_pkg::CMD_PUT) begin
                        if (w_mark_rd != dhkv_pkg::MARK_LIVE) begin
                            r_count <= 9'(r_count + 1'b1);
                            r_state <= S_FINISH;
                        end else if (w_match || w_last) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_READ;
                        end
                    end else begin
                        if (w_mark_rd == dhkv_pkg::MARK_LIVE && w_match) begin
                            if (r_cmd == dhkv_pkg::CMD_REMOVE) begin
                                r_count <= 9'(r_count - 1'b1);
                            end
                            r_state <= S_FINISH;
                        end else if (w_mark_rd == dhkv_pkg::MARK_EMPTY || w_last) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_cmd    <= w_in_cmd;
            r_key    <= w_norm;
            r_val    <= VALUE_WIDTH'(i_s_tdata[97:66]);
            r_sum    <= w_sum;
            r_vout   <= '0;
            r_status <= (w_in_cmd == dhkv_pkg::CMD_PUT) ? dhkv_pkg::ST_FULL
                                                        : dhkv_pkg::ST_ABSENT;
        end
        if (r_state == S_MODN && w_mod_done) begin
            r_slot <= w_mod_rem;
            r_cnt  <= '0;
        end
        if (r_state == S_MODS && w_mod_done) begin
            r_step <= w_mod_rem;
        end
        if (r_state == S_CHECK) begin
            r_slot <= w_slot_next;
            r_cnt  <= 9'(r_cnt + 1'b1);
            if (r_cmd == dhkv_pkg::CMD_PUT) begin
                if (w_mark_rd != dhkv_pkg::MARK_LIVE) begin
                    r_status <= dhkv_pkg::ST_DONE;
                end else if (w_match) begin
                    r_status <= dhkv_pkg::ST_PRESENT;
                end
            end else if (w_mark_rd == dhkv_pkg::MARK_LIVE && w_match) begin
                r_status <= dhkv_pkg::ST_DONE;
                if (r_cmd == dhkv_pkg::CMD_GET) begin
                    r_vout <= dhkv_pkg::VAL_W'(w_val_rd);
                end
            end
        end
        if (w_load) begin
            r_out_status <= r_status;
            r_out_vout   <= r_vout;
            r_out_count  <= r_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_count, r_out_vout, r_out_status};

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_s_tready)
        else $error("request taken during clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_tready)
        else $error("second request taken before the first finished");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> (r_slot < w_n) && (r_step < w_n) && (r_cnt < w_n))
        else $error("probe slot, step or count out of range");

    a_mod_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_MODN || r_state == S_MODP || r_state == S_MODS))
        else $error("remainder result outside a reduction step");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the double-hashing key/value table.
// Depends on dhkv_pkg and double_hash_key_value_table; predicts every response.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        dhkv_pkg::t_cmd                   cmd;
        logic [dhkv_pkg::KEY_W-1:0]       key;
        logic [dhkv_pkg::VAL_W-1:0]       value;
    } t_request;

    typedef struct packed {
        dhkv_pkg::t_status                status;
        logic [dhkv_pkg::VAL_W-1:0]       value_out;
        logic [dhkv_pkg::CNT_W-1:0]       count;
    } t_response;

    localparam int DEPTH = 256;
    localparam int POOL  = 10;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_valid;
    logic                             o_s_tready;
    logic [103:0]                     s_data;
    logic                             o_m_tvalid;
    logic                             m_ready;
    logic [47:0]                      o_m_tdata;
    logic                             cfg_we;
    logic [dhkv_pkg::IDX_W-1:0]       cfg_index;
    logic [dhkv_pkg::CFG_W-1:0]       cfg_data;

    t_request   pending_requests[$];
    t_response  expected_responses[$];
    t_request   in_flight;

    dhkv_pkg::t_mark                  slot_mark[DEPTH];
    logic [dhkv_pkg::KEY_W-1:0]       slot_key[DEPTH];
    logic [dhkv_pkg::VAL_W-1:0]       slot_value[DEPTH];
    logic [dhkv_pkg::CNT_W-1:0]       live_entries;
    logic [dhkv_pkg::SIZE_W-1:0]      size_reg;
    logic [dhkv_pkg::PRIME_W-1:0]     prime_reg;

    logic [dhkv_pkg::KEY_W-1:0]       pool_key[POOL];
    int                               pool_len[POOL];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_sender;
    int  mismatches;

    double_hash_key_value_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Computes the response of one request and updates the shadow table.
    function automatic t_response apply_request(t_request req);
        t_response                  rsp;
        logic [dhkv_pkg::KEY_W-1:0] norm;
        int                         sum;
        int                         n;
        int                         p;
        int                         slot;
        int                         stride;
        bit                         stop;
        logic [7:0]                 b;
        norm = '0;
        sum = 0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            b = req.key[8*i +: 8];
            if (b == 8'd0) stop = 1'b1;
            if (!stop) begin
                sum += b;
                norm[8*i +: 8] = b;
            end
        end
        n = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
        p = (prime_reg == 0) ? 1 : prime_reg;
        slot = sum % n;
        stride = p - (sum % p);
        rsp.status = (req.cmd == dhkv_pkg::CMD_PUT) ? dhkv_pkg::ST_FULL
                                                    : dhkv_pkg::ST_ABSENT;
        rsp.value_out = '0;
        if (req.cmd != dhkv_pkg::CMD_NONE) begin
            for (int i = 0; i < n; i++) begin
                if (req.cmd == dhkv_pkg::CMD_PUT) begin
                    if (slot_mark[slot] != dhkv_pkg::MARK_LIVE) begin
                        slot_mark[slot] = dhkv_pkg::MARK_LIVE;
                        slot_key[slot] = norm;
                        slot_value[slot] = req.value;
                        live_entries = live_entries + 1'b1;
                        rsp.status = dhkv_pkg::ST_DONE;
                        break;
                    end
                    if (slot_key[slot] == norm) begin
                        rsp.status = dhkv_pkg::ST_PRESENT;
                        break;
                    end
                end else begin
                    if (slot_mark[slot] == dhkv_pkg::MARK_EMPTY) break;
                    if (slot_mark[slot] == dhkv_pkg::MARK_LIVE && slot_key[slot] == norm) begin
                        rsp.status = dhkv_pkg::ST_DONE;
                        if (req.cmd == dhkv_pkg::CMD_GET) begin
                            rsp.value_out = slot_value[slot];
                        end else begin
                            slot_mark[slot] = dhkv_pkg::MARK_DEAD;
                            live_entries = live_entries - 1'b1;
                        end
                        break;
                    end
                end
                slot = (slot + stride) % n;
            end
        end
        rsp.count = live_entries;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && o_s_tready)
                expected_responses.push_back(apply_request(in_flight));
            if (!s_valid || o_s_tready) begin
                if (pending_requests.size() > 0 && !hold_sender
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_requests.pop_front();
                    in_flight <= nxt;
                    s_data <= {6'd0, nxt.value, nxt.key, nxt.cmd};
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_response got;
        t_response want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                got = {o_m_tdata[1:0], o_m_tdata[33:2], o_m_tdata[42:34]};
                if (expected_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected response %h", got);
                end else begin
                    want = expected_responses.pop_front();
                    if (got.status !== want.status || got.value_out !== want.value_out
                            || got.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected st=%0d val=%h cnt=%0d, ",
                                      "got st=%0d val=%h cnt=%0d"},
                                     want.status, want.value_out, want.count,
                                     got.status, got.value_out, got.count);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_cfg(logic [dhkv_pkg::IDX_W-1:0] idx, int data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[dhkv_pkg::CFG_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == dhkv_pkg::CFG_TABLE_SIZE) size_reg = data[dhkv_pkg::SIZE_W-1:0];
        else prime_reg = data[dhkv_pkg::PRIME_W-1:0];
    endtask

    task automatic set_table(int size, int prime);
        write_cfg(dhkv_pkg::CFG_TABLE_SIZE, size);
        write_cfg(dhkv_pkg::CFG_STEP_PRIME, prime);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_valid || expected_responses.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic push(dhkv_pkg::t_cmd cmd, logic [dhkv_pkg::KEY_W-1:0] key,
                        logic [dhkv_pkg::VAL_W-1:0] value);
        t_request req;
        req.cmd = cmd;
        req.key = key;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    // Keys of up to eight nonzero bytes, at random with random bytes after the terminator.
    function automatic logic [dhkv_pkg::KEY_W-1:0] dress_key(
            logic [dhkv_pkg::KEY_W-1:0] norm, int len);
        logic [dhkv_pkg::KEY_W-1:0] k;
        k = norm;
        if (len < 8 && $urandom_range(0, 1))
            for (int i = len + 1; i < 8; i++) k[8*i +: 8] = $urandom_range(0, 255);
        return k;
    endfunction

    task automatic new_pool();
        for (int j = 0; j < POOL; j++) begin
            pool_len[j] = $urandom_range(0, 8);
            pool_key[j] = '0;
            for (int i = 0; i < pool_len[j]; i++)
                pool_key[j][8*i +: 8] = $urandom_range(1, 255);
        end
    endtask

    task automatic random_requests(int count);
        int                         r;
        int                         j;
        int                         len;
        dhkv_pkg::t_cmd             c;
        logic [dhkv_pkg::KEY_W-1:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            c = (r < 40) ? dhkv_pkg::CMD_PUT : (r < 72) ? dhkv_pkg::CMD_GET
              : (r < 95) ? dhkv_pkg::CMD_REMOVE : dhkv_pkg::CMD_NONE;
            if ($urandom_range(0, 99) < 80) begin
                j = $urandom_range(0, POOL - 1);
                k = dress_key(pool_key[j], pool_len[j]);
            end else begin
                k = {$urandom, $urandom};
                len = $urandom_range(0, 7);
                if ($urandom_range(0, 1)) k[8*len +: 8] = 8'd0;
            end
            push(c, k, $urandom);
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_sender = 1'b0;
        mismatches = 0;
        send_idle_pct = 17;
        recv_idle_pct = 64;
        live_entries = '0;
        size_reg = 9'd256;
        prime_reg = 8'd251;
        for (int i = 0; i < DEPTH; i++) begin
            slot_mark[i] = dhkv_pkg::MARK_EMPTY;
            slot_key[i] = '0;
            slot_value[i] = '0;
        end
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push(dhkv_pkg::CMD_GET, 64'd0, 32'hffff_ffff);
        push(dhkv_pkg::CMD_PUT, 64'd0, 32'h1234_5678);
        push(dhkv_pkg::CMD_PUT, 64'd0, 32'h0);
        push(dhkv_pkg::CMD_GET, 64'd0, 32'h0);
        push(dhkv_pkg::CMD_PUT, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        push(dhkv_pkg::CMD_GET, 64'hffff_ffff_ffff_ffff, 32'h0);
        push(dhkv_pkg::CMD_PUT, 64'hdead_beef_0000_4241, 32'h0000_0001);
        push(dhkv_pkg::CMD_GET, 64'h0000_0000_0000_4241, 32'h0);
        push(dhkv_pkg::CMD_GET, 64'h1111_0000_0000_4241, 32'h0);
        push(dhkv_pkg::CMD_PUT, 64'h0000_0000_0000_4142, 32'h0000_0002);
        push(dhkv_pkg::CMD_REMOVE, 64'h0000_0000_0000_4241, 32'h0);
        push(dhkv_pkg::CMD_REMOVE, 64'h0000_0000_0000_4241, 32'h0);
        push(dhkv_pkg::CMD_GET, 64'h0000_0000_0000_4142, 32'h0);
        push(dhkv_pkg::CMD_NONE, 64'h0000_0000_0000_4142, 32'hffff_ffff);
        push(dhkv_pkg::CMD_REMOVE, 64'd0, 32'h0);
        new_pool();
        random_requests(150);
        wait_drained();

        set_table(1, 1);
        push(dhkv_pkg::CMD_PUT, 64'h41, 32'haaaa_5555);
        push(dhkv_pkg::CMD_PUT, 64'h42, 32'h5555_aaaa);
        push(dhkv_pkg::CMD_GET, 64'h42, 32'h0);
        push(dhkv_pkg::CMD_REMOVE, 64'h41, 32'h0);
        push(dhkv_pkg::CMD_PUT, 64'h42, 32'h0000_0003);
        push(dhkv_pkg::CMD_REMOVE, 64'h99, 32'h0);
        new_pool();
        random_requests(40);
        wait_drained();

        send_idle_pct = 64;
        recv_idle_pct = 17;
        set_table(0, 0);
        random_requests(30);
        wait_drained();
        set_table(300, 255);
        new_pool();
        random_requests(150);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_table(7, 5);
        new_pool();
        random_requests(150);
        while (pending_requests.size() > 75) @(posedge i_clk);
        hold_sender = 1'b1;
        while (s_valid || expected_responses.size() > 0) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();
        set_table(4, 3);
        random_requests(60);
        wait_drained();
        set_table(256, 251);
        new_pool();
        random_requests(120);
        wait_drained();
        repeat (600) @(posedge i_clk);

        if (mismatches == 0 && expected_responses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
